FILE: sv/snrp_pkg.sv
// Shared types, constants and helper functions for the netstring request parser.
// Used by snrp_core and by the top level space_netstring_request_parser.
// Depends on nothing.
package snrp_pkg;

   // Largest message the byte position counter is sized for.
   localparam int MAX_MSG_BYTES = 65536;

   // Position saturation value: min(MAX_MSG_BYTES - 1, 65535).
   localparam logic [15:0] POS_TOP =
      (MAX_MSG_BYTES - 1 > 65535) ? 16'hFFFF : 16'(MAX_MSG_BYTES - 1);

   // Character codes of the message syntax.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Status codes of a finished message.
   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_MISSING_SPACE = 3'd1;
   localparam logic [2:0] ST_HDR_COLON     = 3'd2;
   localparam logic [2:0] ST_HDR_LONG      = 3'd3;
   localparam logic [2:0] ST_BODY_COLON    = 3'd4;
   localparam logic [2:0] ST_BODY_LONG     = 3'd5;

   // Parser phases: one per name field, and lead, digit, seek and data phases for the header and body.
   typedef enum logic [3:0] {
      PH_IDENT  = 4'd0,
      PH_CLIENT = 4'd1,
      PH_PATH   = 4'd2,
      PH_HLEAD  = 4'd3,
      PH_HDIG   = 4'd4,
      PH_HSEEK  = 4'd5,
      PH_HDATA  = 4'd6,
      PH_BLEAD  = 4'd7,
      PH_BDIG   = 4'd8,
      PH_BSEEK  = 4'd9,
      PH_BDATA  = 4'd10
   } phase_type;

   // One result of a finished message.
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] ident_length;
      logic [15:0] client_offset;
      logic [15:0] client_length;
      logic [15:0] path_offset;
      logic [15:0] path_length;
      logic [15:0] headers_offset;
      logic [15:0] headers_length;
      logic [15:0] body_offset;
      logic [15:0] body_length;
   } result_type;

   // Advance a byte position, holding at the saturation value.
   function automatic logic [15:0] next_pos(input logic [15:0] pos);
      next_pos = (pos >= POS_TOP) ? POS_TOP : pos + 16'd1;
   endfunction

   // Append one decimal digit to a length, saturating at 65535.
   function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [3:0] dig);
      logic [19:0] sum;
      sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {16'd0, dig};
      acc_digit = (sum > 20'd65535) ? 16'hFFFF : sum[15:0];
   endfunction

endpackage

FILE: sv/snrp_core.sv
// Parser state and per-byte update logic of the netstring request parser.
// Consumes one registered byte per step and forms the result on the final byte.
// Depends on snrp_pkg.
module snrp_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output logic                   res_fire,
   output snrp_pkg::result_type   res
);
   import snrp_pkg::*;

   phase_type   phase_ff, phase_in, phase_upd;
   logic [15:0] position_ff, position_in;
   logic [15:0] skip_ff, skip_in, skip_upd;
   logic [15:0] ident_len_ff, ident_len_in, ident_len_upd;
   logic [15:0] client_off_ff, client_off_in, client_off_upd;
   logic [15:0] client_len_ff, client_len_in, client_len_upd;
   logic [15:0] path_off_ff, path_off_in, path_off_upd;
   logic [15:0] path_len_ff, path_len_in, path_len_upd;
   logic [15:0] hdr_off_ff, hdr_off_in, hdr_off_upd;
   logic [15:0] hdr_len_ff, hdr_len_in, hdr_len_upd;
   logic [15:0] body_off_ff, body_off_in, body_off_upd;
   logic [15:0] body_len_ff, body_len_in, body_len_upd;
   logic [15:0] pos_next;
   logic        is_space, is_colon, is_digit;
   logic [2:0]  status;

   // Character classes of the current byte.
   assign is_space = (data_byte == CHAR_SPACE);
   assign is_colon = (data_byte == CHAR_COLON);
   assign is_digit = (data_byte inside {[CHAR_ZERO:CHAR_NINE]});
   assign pos_next = next_pos(position_ff);

   // Next phase after this byte.
   always_comb begin
      phase_upd = phase_ff;
      case (phase_ff)
         PH_IDENT:  if (is_space) phase_upd = PH_CLIENT;
         PH_CLIENT: if (is_space) phase_upd = PH_PATH;
         PH_PATH:   if (is_space) phase_upd = PH_HLEAD;
         PH_HLEAD: begin
            if (is_colon)      phase_upd = PH_HDATA;
            else if (is_digit) phase_upd = PH_HDIG;
            else if (!is_space) phase_upd = PH_HSEEK;
         end
         PH_HDIG: begin
            if (is_colon)       phase_upd = PH_HDATA;
            else if (!is_digit) phase_upd = PH_HSEEK;
         end
         PH_HSEEK:  if (is_colon) phase_upd = PH_HDATA;
         PH_HDATA:  if (skip_ff >= hdr_len_ff) phase_upd = PH_BLEAD;
         PH_BLEAD: begin
            if (is_colon)       phase_upd = PH_BDATA;
            else if (is_digit)  phase_upd = PH_BDIG;
            else if (!is_space) phase_upd = PH_BSEEK;
         end
         PH_BDIG: begin
            if (is_colon)       phase_upd = PH_BDATA;
            else if (!is_digit) phase_upd = PH_BSEEK;
         end
         PH_BSEEK:  if (is_colon) phase_upd = PH_BDATA;
         PH_BDATA:  phase_upd = PH_BDATA;
         default:   phase_upd = PH_IDENT;
      endcase
   end

   // Field offsets, lengths and the data skip counter after this byte.
   always_comb begin
      skip_upd       = skip_ff;
      ident_len_upd  = ident_len_ff;
      client_off_upd = client_off_ff;
      client_len_upd = client_len_ff;
      path_off_upd   = path_off_ff;
      path_len_upd   = path_len_ff;
      hdr_off_upd    = hdr_off_ff;
      hdr_len_upd    = hdr_len_ff;
      body_off_upd   = body_off_ff;
      body_len_upd   = body_len_ff;
      case (phase_ff)
         PH_IDENT: begin
            if (is_space) begin
               ident_len_upd  = position_ff;
               client_off_upd = pos_next;
            end
         end
         PH_CLIENT: begin
            if (is_space) begin
               client_len_upd = position_ff - client_off_ff;
               path_off_upd   = pos_next;
            end
         end
         PH_PATH: begin
            if (is_space) begin
               path_len_upd = position_ff - path_off_ff;
               hdr_len_upd  = 16'd0;
            end
         end
         PH_HLEAD, PH_HDIG: begin
            if (is_colon) begin
               hdr_off_upd = pos_next;
               skip_upd    = 16'd0;
            end else if (is_digit) begin
               hdr_len_upd = acc_digit(hdr_len_ff, data_byte[3:0]);
            end
         end
         PH_HSEEK: begin
            if (is_colon) begin
               hdr_off_upd = pos_next;
               skip_upd    = 16'd0;
            end
         end
         PH_HDATA: begin
            if (skip_ff >= hdr_len_ff) body_len_upd = 16'd0;
            else                       skip_upd = skip_ff + 16'd1;
         end
         PH_BLEAD, PH_BDIG: begin
            if (is_colon) begin
               body_off_upd = pos_next;
               skip_upd     = 16'd0;
            end else if (is_digit) begin
               body_len_upd = acc_digit(body_len_ff, data_byte[3:0]);
            end
         end
         PH_BSEEK: begin
            if (is_colon) begin
               body_off_upd = pos_next;
               skip_upd     = 16'd0;
            end
         end
         PH_BDATA: begin
            if (skip_ff != 16'hFFFF) skip_upd = skip_ff + 16'd1;
         end
         default: skip_upd = skip_ff;
      endcase
   end

   // Status of a message that ends with this byte.
   always_comb begin
      case (phase_upd)
         PH_IDENT, PH_CLIENT, PH_PATH: status = ST_MISSING_SPACE;
         PH_HLEAD, PH_HDIG, PH_HSEEK:  status = ST_HDR_COLON;
         PH_HDATA:                     status = ST_HDR_LONG;
         PH_BLEAD, PH_BDIG, PH_BSEEK:  status = ST_BODY_COLON;
         default: status = (body_len_upd >= skip_upd) ? ST_BODY_LONG : ST_OK;
      endcase
   end

   // Result fields; all but the status are zero when the message failed.
   always_comb begin
      res_fire = step_en && last_byte;
      res      = '0;
      res.status = status;
      if (status == ST_OK) begin
         res.ident_length   = ident_len_upd;
         res.client_offset  = client_off_upd;
         res.client_length  = client_len_upd;
         res.path_offset    = path_off_upd;
         res.path_length    = path_len_upd;
         res.headers_offset = hdr_off_upd;
         res.headers_length = hdr_len_upd;
         res.body_offset    = body_off_upd;
         res.body_length    = body_len_upd;
      end
   end

   // Register inputs: hold when idle, start over after the final byte.
   always_comb begin
      phase_in      = phase_ff;
      position_in   = position_ff;
      skip_in       = skip_ff;
      ident_len_in  = ident_len_ff;
      client_off_in = client_off_ff;
      client_len_in = client_len_ff;
      path_off_in   = path_off_ff;
      path_len_in   = path_len_ff;
      hdr_off_in    = hdr_off_ff;
      hdr_len_in    = hdr_len_ff;
      body_off_in   = body_off_ff;
      body_len_in   = body_len_ff;
      if (step_en) begin
         if (last_byte) begin
            phase_in      = PH_IDENT;
            position_in   = '0;
            skip_in       = '0;
            ident_len_in  = '0;
            client_off_in = '0;
            client_len_in = '0;
            path_off_in   = '0;
            path_len_in   = '0;
            hdr_off_in    = '0;
            hdr_len_in    = '0;
            body_off_in   = '0;
            body_len_in   = '0;
         end else begin
            phase_in      = phase_upd;
            position_in   = pos_next;
            skip_in       = skip_upd;
            ident_len_in  = ident_len_upd;
            client_off_in = client_off_upd;
            client_len_in = client_len_upd;
            path_off_in   = path_off_upd;
            path_len_in   = path_len_upd;
            hdr_off_in    = hdr_off_upd;
            hdr_len_in    = hdr_len_upd;
            body_off_in   = body_off_upd;
            body_len_in   = body_len_upd;
         end
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDENT;
         position_ff   <= '0;
         skip_ff       <= '0;
         ident_len_ff  <= '0;
         client_off_ff <= '0;
         client_len_ff <= '0;
         path_off_ff   <= '0;
         path_len_ff   <= '0;
         hdr_off_ff    <= '0;
         hdr_len_ff    <= '0;
         body_off_ff   <= '0;
         body_len_ff   <= '0;
      end else begin
         phase_ff      <= phase_in;
         position_ff   <= position_in;
         skip_ff       <= skip_in;
         ident_len_ff  <= ident_len_in;
         client_off_ff <= client_off_in;
         client_len_ff <= client_len_in;
         path_off_ff   <= path_off_in;
         path_len_ff   <= path_len_in;
         hdr_off_ff    <= hdr_off_in;
         hdr_len_ff    <= hdr_len_in;
         body_off_ff   <= body_off_in;
         body_len_ff   <= body_len_in;
      end
   end

   // A final byte always leaves the parser at the start of a new message.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (step_en && last_byte) |=> (phase_ff == PH_IDENT && position_ff == 16'd0))
      else $error("parser did not restart after the final byte");

   // The header data counter never passes the header length.
   a_hdr_skip: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HDATA) |-> (skip_ff <= hdr_len_ff))
      else $error("header skip count ran past the header length");

   // The byte position stays within its saturation value.
   a_pos_top: assert property (@(posedge clock) disable iff (reset)
      position_ff <= POS_TOP)
      else $error("byte position above its saturation value");

endmodule

FILE: sv/space_netstring_request_parser.sv
// Top level of the netstring request parser: input byte register, parser
// core and result register with the valid/stall handshakes.
// Depends on snrp_pkg and snrp_core.
//
// Usage:
// The request channel (req_valid, req_stall, req_data_byte, req_last_byte)
// carries one message byte per transfer; req_last_byte marks the final byte.
// Each message gives exactly one transfer on the result channel (rsp_valid,
// rsp_stall, rsp_status and the offset/length fields), made from its final
// byte. A failed message reports a nonzero status and zero fields.
// Throughput is one byte per cycle while rsp_stall does not hold a result:
// the byte register feeds the parser, which updates its state and forms the
// result combinationally; the final byte then enters the result register.
// While a result waits under rsp_stall, the next byte is still taken into the
// byte register; that byte waits there, and req_stall rises, until the result
// register is free again. Results are never dropped or repeated.
// Reset is synchronous and active high; it empties both registers and
// returns the parser to the start of a message. No setup is needed.
module space_netstring_request_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_ident_length,
   output logic [15:0] rsp_client_offset,
   output logic [15:0] rsp_client_length,
   output logic [15:0] rsp_path_offset,
   output logic [15:0] rsp_path_length,
   output logic [15:0] rsp_headers_offset,
   output logic [15:0] rsp_headers_length,
   output logic [15:0] rsp_body_offset,
   output logic [15:0] rsp_body_length
);
   import snrp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;
   logic       req_xfer, advance, res_fire;
   result_type res;

   // The byte register drains whenever the result register can take a result.
   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   snrp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .res_fire  (res_fire),
      .res       (res)
   );

   // Valid bits of the byte register and the result register.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (res_fire)                   out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (res_fire) begin
         out_res_ff <= res;
      end
   end

   // Result channel ports.
   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_res_ff.status;
   assign rsp_ident_length   = out_res_ff.ident_length;
   assign rsp_client_offset  = out_res_ff.client_offset;
   assign rsp_client_length  = out_res_ff.client_length;
   assign rsp_path_offset    = out_res_ff.path_offset;
   assign rsp_path_length    = out_res_ff.path_length;
   assign rsp_headers_offset = out_res_ff.headers_offset;
   assign rsp_headers_length = out_res_ff.headers_length;
   assign rsp_body_offset    = out_res_ff.body_offset;
   assign rsp_body_length    = out_res_ff.body_length;

   // A waiting byte is not consumed while the result register is blocked.
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |=> in_valid_ff)
      else $error("byte register drained into a blocked result register");

   // A failed message reports only its status.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.status != ST_OK) |->
         (out_res_ff.ident_length == 16'd0 && out_res_ff.headers_length == 16'd0 &&
          out_res_ff.body_offset == 16'd0 && out_res_ff.body_length == 16'd0))
      else $error("failed message carries nonzero fields");

endmodule

FILE: dv/snrp_checker.sv
// Scoreboard for the netstring request parser: watches both channels, predicts
// each message result from the accepted bytes and compares it field by field.
// Depends on snrp_pkg for the phase enum, status codes and result struct.
module snrp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [15:0] rsp_ident_length,
   input  logic [15:0] rsp_client_offset,
   input  logic [15:0] rsp_client_length,
   input  logic [15:0] rsp_path_offset,
   input  logic [15:0] rsp_path_length,
   input  logic [15:0] rsp_headers_offset,
   input  logic [15:0] rsp_headers_length,
   input  logic [15:0] rsp_body_offset,
   input  logic [15:0] rsp_body_length,
   output int          mismatches,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import snrp_pkg::*;

   // Parser state as the predictor tracks it.
   phase_type   stage;
   logic [15:0] byte_pos;
   logic [15:0] data_count;
   logic [15:0] id_len;
   logic [15:0] cl_off;
   logic [15:0] cl_len;
   logic [15:0] pa_off;
   logic [15:0] pa_len;
   logic [15:0] hd_off;
   logic [15:0] hd_len;
   logic [15:0] bd_off;
   logic [15:0] bd_len;

   // Results predicted but not yet seen on the result channel.
   result_type awaited_results[$];
   int         result_index;

   // Byte position moves up by one and holds at the top value.
   function automatic logic [15:0] step_pos(input logic [15:0] p);
      return (p >= POS_TOP) ? POS_TOP : p + 16'd1;
   endfunction

   // Shift one decimal digit into a length, holding at the 16-bit maximum.
   function automatic logic [15:0] add_decimal(input logic [15:0] acc, input logic [7:0] ch);
      int unsigned total;
      total = 32'(acc) * 10 + 32'(ch - CHAR_ZERO);
      return (total > 32'd65535) ? 16'hFFFF : total[15:0];
   endfunction

   // Start of a new message.
   task automatic clear_parse();
      stage      = PH_IDENT;
      byte_pos   = '0;
      data_count = '0;
      id_len     = '0;
      cl_off     = '0;
      cl_len     = '0;
      pa_off     = '0;
      pa_len     = '0;
      hd_off     = '0;
      hd_len     = '0;
      bd_off     = '0;
      bd_len     = '0;
   endtask

   // Length field: skip spaces, gather digits, then hunt for the colon.
   task automatic take_length_byte(input logic [7:0] ch, inout logic [15:0] len,
                                   inout logic [15:0] off, input phase_type lead,
                                   input phase_type digits, input phase_type seek,
                                   input phase_type done);
      logic is_digit;
      is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      if (ch == CHAR_COLON) begin
         off        = step_pos(byte_pos);
         data_count = '0;
         stage      = done;
      end else if (stage == lead) begin
         if (is_digit) begin
            len   = add_decimal(len, ch);
            stage = digits;
         end else if (ch != CHAR_SPACE) begin
            stage = seek;
         end
      end else if (stage == digits) begin
         if (is_digit) len = add_decimal(len, ch);
         else stage = seek;
      end
   endtask

   // Advance the predicted parser by one accepted byte.
   task automatic take_byte(input logic [7:0] ch, input logic fin);
      result_type r;
      logic [2:0] st;
      case (stage)
         PH_IDENT: begin
            if (ch == CHAR_SPACE) begin
               id_len = byte_pos;
               cl_off = step_pos(byte_pos);
               stage  = PH_CLIENT;
            end
         end
         PH_CLIENT: begin
            if (ch == CHAR_SPACE) begin
               cl_len = byte_pos - cl_off;
               pa_off = step_pos(byte_pos);
               stage  = PH_PATH;
            end
         end
         PH_PATH: begin
            if (ch == CHAR_SPACE) begin
               pa_len = byte_pos - pa_off;
               hd_len = '0;
               stage  = PH_HLEAD;
            end
         end
         PH_HLEAD, PH_HDIG, PH_HSEEK: begin
            take_length_byte(ch, hd_len, hd_off, PH_HLEAD, PH_HDIG, PH_HSEEK, PH_HDATA);
         end
         PH_HDATA: begin
            // The byte after the header data is skipped before the body length.
            if (data_count >= hd_len) begin
               bd_len = '0;
               stage  = PH_BLEAD;
            end else begin
               data_count = data_count + 16'd1;
            end
         end
         PH_BLEAD, PH_BDIG, PH_BSEEK: begin
            take_length_byte(ch, bd_len, bd_off, PH_BLEAD, PH_BDIG, PH_BSEEK, PH_BDATA);
         end
         default: begin
            if (data_count != 16'hFFFF) data_count = data_count + 16'd1;
         end
      endcase
      byte_pos = step_pos(byte_pos);

      if (fin) begin
         // The phase reached at the final byte decides the status.
         if (stage <= PH_PATH) st = ST_MISSING_SPACE;
         else if (stage <= PH_HSEEK) st = ST_HDR_COLON;
         else if (stage == PH_HDATA) st = ST_HDR_LONG;
         else if (stage <= PH_BSEEK) st = ST_BODY_COLON;
         else if (bd_len >= data_count) st = ST_BODY_LONG;
         else st = ST_OK;

         r = '0;
         r.status = st;
         if (st == ST_OK) begin
            r.ident_length   = id_len;
            r.client_offset  = cl_off;
            r.client_length  = cl_len;
            r.path_offset    = pa_off;
            r.path_length    = pa_len;
            r.headers_offset = hd_off;
            r.headers_length = hd_len;
            r.body_offset    = bd_off;
            r.body_length    = bd_len;
         end
         awaited_results.push_back(r);
         clear_parse();
      end
   endtask

   // One line per mismatch, and the count goes up.
   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatches = mismatches + 1;
      $display("%0t: result %0d %s: got %0d, expected %0d",
               $realtime, result_index, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Predict on every byte transfer and check on every result transfer.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_parse();
         awaited_results.delete();
         result_index = 0;
      end else begin
         if (req_valid && !req_stall) take_byte(req_data_byte, req_last_byte);

         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("arrived with nothing pending, status", 16'(rsp_status), '0);
            end else begin
               want = awaited_results.pop_front();
               check_field("status", 16'(rsp_status), 16'(want.status));
               check_field("ident_length", rsp_ident_length, want.ident_length);
               check_field("client_offset", rsp_client_offset, want.client_offset);
               check_field("client_length", rsp_client_length, want.client_length);
               check_field("path_offset", rsp_path_offset, want.path_offset);
               check_field("path_length", rsp_path_length, want.path_length);
               check_field("headers_offset", rsp_headers_offset, want.headers_offset);
               check_field("headers_length", rsp_headers_length, want.headers_length);
               check_field("body_offset", rsp_body_offset, want.body_offset);
               check_field("body_length", rsp_body_length, want.body_length);
            end
            result_index = result_index + 1;
         end
      end
      pending = awaited_results.size();
   end

endmodule

FILE: dv/tb_space_netstring_request_parser.sv
// Testbench top for space_netstring_request_parser: drives request messages
// with random gaps and result stalls, and gives the verdict.
// Depends on snrp_pkg, the parser RTL and snrp_checker.
module tb_space_netstring_request_parser;
   timeunit 1ns;
   timeprecision 1ps;
   import snrp_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_ident_length;
   logic [15:0] rsp_client_offset;
   logic [15:0] rsp_client_length;
   logic [15:0] rsp_path_offset;
   logic [15:0] rsp_path_length;
   logic [15:0] rsp_headers_offset;
   logic [15:0] rsp_headers_length;
   logic [15:0] rsp_body_offset;
   logic [15:0] rsp_body_length;

   int          mismatches;
   int          pending;
   int          cycle_count = 0;
   int          byte_total = 0;
   int          stall_left;
   bit          no_gaps;
   bit          rsp_quiet;
   logic [7:0]  msg_bytes[$];

   space_netstring_request_parser i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_ident_length   (rsp_ident_length),
      .rsp_client_offset  (rsp_client_offset),
      .rsp_client_length  (rsp_client_length),
      .rsp_path_offset    (rsp_path_offset),
      .rsp_path_length    (rsp_path_length),
      .rsp_headers_offset (rsp_headers_offset),
      .rsp_headers_length (rsp_headers_length),
      .rsp_body_offset    (rsp_body_offset),
      .rsp_body_length    (rsp_body_length)
   );

   snrp_checker i_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_ident_length   (rsp_ident_length),
      .rsp_client_offset  (rsp_client_offset),
      .rsp_client_length  (rsp_client_length),
      .rsp_path_offset    (rsp_path_offset),
      .rsp_path_length    (rsp_path_length),
      .rsp_headers_offset (rsp_headers_offset),
      .rsp_headers_length (rsp_headers_length),
      .rsp_body_offset    (rsp_body_offset),
      .rsp_body_length    (rsp_body_length),
      .mismatches         (mismatches),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side: after each transfer, hold stall for a random number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) stall_left = rsp_quiet ? 0 : $urandom_range(0, 8);
         else if (stall_left > 0) stall_left = stall_left - 1;
         rsp_stall <= (stall_left > 0);
      end
   end

   // Any byte except a space, so a name field does not end early.
   function automatic logic [7:0] name_char();
      logic [7:0] b;
      do b = 8'($urandom); while (b == CHAR_SPACE);
      return b;
   endfunction

   // A byte that is neither a digit, a colon nor a space.
   function automatic logic [7:0] junk_char();
      logic [7:0] b;
      do b = 8'($urandom); while ((b >= CHAR_ZERO && b <= CHAR_COLON) || b == CHAR_SPACE);
      return b;
   endfunction

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
   endtask

   task automatic add_field(input int n);
      repeat (n) msg_bytes.push_back(name_char());
   endtask

   task automatic add_any(input int n);
      repeat (n) msg_bytes.push_back(8'($urandom));
   endtask

   // Length text and its colon; parsed returns what the block should read.
   task automatic add_length(input int val, output int parsed);
      int kind;
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) msg_bytes.push_back(CHAR_SPACE);
      if (kind == 0) begin
         // A sign stops the scan, so the digits after it do not count.
         add_text($urandom_range(0, 1) ? "+" : "-");
         add_text($sformatf("%0d", val));
         parsed = 0;
      end else if (kind == 1) begin
         msg_bytes.push_back(junk_char());
         parsed = 0;
      end else if (kind == 2) begin
         add_text($urandom_range(0, 1) ? "99999" : "70000");
         parsed = 65535;
      end else begin
         repeat ($urandom_range(0, 2)) msg_bytes.push_back(CHAR_ZERO);
         add_text($sformatf("%0d", val));
         parsed = val;
      end
      if ($urandom_range(0, 3) == 0) begin
         msg_bytes.push_back(junk_char());
         if ($urandom_range(0, 1) == 1) msg_bytes.push_back(CHAR_SPACE);
      end
      msg_bytes.push_back(CHAR_COLON);
   endtask

   // A request in the message syntax with random content; lengths are mostly short, some malformed or saturated.
   task automatic build_request();
      int hd;
      int bd;
      int n;
      add_field($urandom_range(0, 4));
      msg_bytes.push_back(CHAR_SPACE);
      add_field($urandom_range(0, 4));
      msg_bytes.push_back(CHAR_SPACE);
      add_field($urandom_range(0, 5));
      msg_bytes.push_back(CHAR_SPACE);
      add_length($urandom_range(0, 6), hd);
      add_any((hd > 8) ? 2 : hd + 1);
      add_length($urandom_range(0, 6), bd);
      case ($urandom_range(0, 5))
         0: n = bd;
         1: n = 0;
         default: n = bd + $urandom_range(1, 3);
      endcase
      if (bd > 8) n = $urandom_range(0, 3);
      add_any(n);
   endtask

   // One byte transfer, after a random gap unless the message is sent back to back.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid     <= 1'b0;
         req_data_byte <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      do @(posedge clock); while (req_stall);
      byte_total = byte_total + 1;
   endtask

   task automatic send_message(input bit steady);
      no_gaps   = steady || ($urandom_range(0, 4) == 0);
      rsp_quiet = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < msg_bytes.size(); i++)
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      msg_bytes.delete();
   endtask

   // Hold the request side idle until every predicted result has come out.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      int msg_total;
      int sel;
      int k;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      no_gaps       = 1'b0;
      rsp_quiet     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed messages: good ones, each status, leading spaces, signs,
      // saturating lengths and colons on the final byte.
      add_text("id cl /p 3:abcX2:xyz");   send_message(0);
      add_text("   0:Q0:z");              send_message(0);
      add_text("a b c   1x:Hs  +5:bb");   send_message(0);
      add_text("a b c 4:");               send_message(0);
      add_text("a b c 0:s3:");            send_message(0);
      add_text("abc");                    send_message(0);
      add_text("x");                      send_message(1);
      add_text("a b c 12");               send_message(0);
      add_text("a b c 5:ab");             send_message(0);
      add_text("a b c 0:s7");             send_message(0);
      add_text("a b c 0:s3:abc");         send_message(0);
      add_text("a b c 0:s0123456789:xy"); send_message(0);
      add_text("q r s 70000:ab");         send_message(0);
      msg_bytes.push_back(8'h00);
      msg_bytes.push_back(8'hFF);
      msg_bytes.push_back(CHAR_SPACE);
      msg_bytes.push_back(8'h80);
      msg_bytes.push_back(CHAR_SPACE);
      msg_bytes.push_back(8'h7F);
      add_text(" 1:");
      msg_bytes.push_back(8'hFF);
      msg_bytes.push_back(8'h00);
      add_text("1:");
      msg_bytes.push_back(8'hFF);
      msg_bytes.push_back(8'h00);
      send_message(0);
      drain_results();

      // Random traffic: mostly requests built in the message syntax, some cut short, some noise.
      msg_total = 0;
      while (byte_total < 950 || msg_total < 40) begin
         sel = $urandom_range(0, 9);
         if (sel < 9) begin
            build_request();
            if (sel >= 7) begin
               k = $urandom_range(1, msg_bytes.size());
               msg_bytes = msg_bytes[0:k-1];
            end
         end else begin
            repeat ($urandom_range(1, 12))
               msg_bytes.push_back(($urandom_range(0, 2) == 0) ? CHAR_SPACE : 8'($urandom));
         end
         send_message(0);
         msg_total = msg_total + 1;
         if (msg_total == 20) drain_results();
      end

      drain_results();
      repeat (5) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
